FILE: sv/ffha_pkg.sv
// Shared constants, command types and cell records for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int ADDR_W            = 17;
  localparam int TOT_W             = ADDR_W + 1;
  localparam int MAX_HEAP_BYTES    = 65536;
  localparam int MIN_HEAP_BYTES    = 16;
  localparam int MAX_FREE_BLOCKS   = 64;
  localparam int MAX_USED_BLOCKS   = 64;
  localparam int HEADER_BYTES      = 8;
  localparam int FREE_HEADER_BYTES = 16;
  localparam int FCNT_W            = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int SCAN_W            = $clog2((MAX_FREE_BLOCKS > MAX_USED_BLOCKS) ?
                                            MAX_FREE_BLOCKS : MAX_USED_BLOCKS);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_BAD_FREE = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [3:0] {
    F_IDLE,
    F_INIT,
    F_MARK,
    F_SCAN,
    F_DELETE,
    F_INSERT,
    F_ADD_PRE,
    F_ADD_NEXT,
    F_SET_BND,
    F_SUB_TOK
  } fop_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_INIT,
    U_MARK,
    U_SCAN,
    U_WRITE,
    U_CLEAR
  } uop_t;

  typedef struct packed {
    fop_t              op;
    logic [ADDR_W-1:0] key;
    logic [ADDR_W-1:0] start;
    logic [TOT_W-1:0]  total;
    logic [TOT_W:0]    total16;
  } fcmd_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
    logic              r;
    logic              fit;
    logic              tok;
  } fent_t;

  typedef struct packed {
    uop_t              op;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } ucmd_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic              m;
    logic              tok;
  } uent_t;

endpackage
`default_nettype wire

FILE: sv/ffha_free_cell.sv
// One entry of the address-ordered free list chain.
`default_nettype none
module ffha_free_cell import ffha_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  is_head,
  input  fcmd_t cmd,
  input  fent_t prv,
  input  fent_t nxt,
  output fent_t ent,
  output logic  pre,
  output logic  bnd
);

  logic              valid;
  logic [ADDR_W-1:0] start;
  logic [ADDR_W-1:0] len;
  logic              r;
  logic              fit;
  logic              tok;

  // r marks this entry and everything above the split point
  assign pre = !r && nxt.r;
  assign bnd = r && !prv.r;
  assign ent = '{valid: valid, start: start, len: len, r: r, fit: fit, tok: tok};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= is_head;
      start <= '0;
      len   <= ADDR_W'(MAX_HEAP_BYTES);
      r     <= 1'b0;
      fit   <= 1'b0;
      tok   <= 1'b0;
    end else begin
      case (cmd.op)
        F_INIT: begin
          valid <= is_head;
          start <= '0;
          len   <= cmd.key;
          r     <= 1'b0;
          fit   <= 1'b0;
          tok   <= 1'b0;
        end
        F_MARK: begin
          r   <= !valid || (start >= cmd.key);
          fit <= valid && (({1'b0, len} == cmd.total) || ({2'b00, len} >= cmd.total16));
          tok <= 1'b0;
        end
        F_SCAN: begin
          tok <= prv.tok;
        end
        F_DELETE: begin
          if (r) begin
            valid <= nxt.valid;
            start <= nxt.start;
            len   <= nxt.len;
          end
        end
        F_INSERT: begin
          if (bnd) begin
            valid <= 1'b1;
            start <= cmd.start;
            len   <= cmd.total[ADDR_W-1:0];
          end else if (r) begin
            valid <= prv.valid;
            start <= prv.start;
            len   <= prv.len;
          end
        end
        F_ADD_PRE: begin
          if (pre) len <= len + cmd.total[ADDR_W-1:0];
        end
        F_ADD_NEXT: begin
          if (pre) len <= len + nxt.len;
        end
        F_SET_BND: begin
          if (bnd) begin
            start <= cmd.start;
            len   <= len + cmd.total[ADDR_W-1:0];
          end
        end
        F_SUB_TOK: begin
          if (tok) len <= len - cmd.total[ADDR_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/ffha_used_cell.sv
// One entry of the live allocation chain.
`default_nettype none
module ffha_used_cell import ffha_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  ucmd_t cmd,
  input  logic  prv_tok,
  output uent_t ent
);

  logic              valid;
  logic [ADDR_W-1:0] start;
  logic [ADDR_W-1:0] size;
  logic              m;
  logic              tok;

  assign ent = '{valid: valid, start: start, size: size, m: m, tok: tok};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      m     <= 1'b0;
      tok   <= 1'b0;
    end else begin
      case (cmd.op)
        U_INIT: begin
          valid <= 1'b0;
          m     <= 1'b0;
          tok   <= 1'b0;
        end
        U_MARK: begin
          m   <= valid && (start == cmd.start);
          tok <= 1'b0;
        end
        U_SCAN: begin
          tok <= prv_tok;
        end
        U_WRITE: begin
          if (tok) begin
            valid <= 1'b1;
            start <= cmd.start;
            size  <= cmd.size;
          end
        end
        U_CLEAR: begin
          if (m) valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/first_fit_heap_allocator.sv
// Top level: allocation sequencer driving the free list and live allocation chains.
// An allocate walks a token along the free chain (once per size tried) and then along
// the allocation chain, one cell a cycle.
// Throughput: one transaction in flight; the next is taken once the result is registered.
// Reset: one free block of 65536 bytes at 0, no allocations, ready in the next cycle.
`default_nettype none
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ADDR_W-1:0] heap_bytes,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [ADDR_W-1:0] request_bytes,
  input  logic [ADDR_W-1:0] user_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [ADDR_W-1:0] result_address
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_AMARK,
    S_AFSTART,
    S_AFSCAN,
    S_AUSTART,
    S_AUSCAN,
    S_ACOMMIT,
    S_ADEL,
    S_FMATCH,
    S_FLOOK,
    S_FNB,
    S_FJOIN,
    S_FADDNX,
    S_FDEL,
    S_FCLR,
    S_DONE
  } state_t;

  localparam logic [TOT_W-1:0] RND_MASK = ~TOT_W'(FREE_HEADER_BYTES - 1);

  state_t              state;
  logic [ADDR_W-1:0]   req;
  logic [ADDR_W-1:0]   ua;
  logic [TOT_W-1:0]    size;
  logic [TOT_W-1:0]    tot;
  logic                pass;
  logic [SCAN_W-1:0]   cnt;
  logic [ADDR_W-1:0]   fs;
  logic [ADDR_W-1:0]   fl;
  logic                pv;
  logic [ADDR_W-1:0]   ps;
  logic [ADDR_W-1:0]   pl;
  logic                nv;
  logic [ADDR_W-1:0]   ns;
  logic [FCNT_W-1:0]   fcount;
  logic [2:0]          st;
  logic [ADDR_W-1:0]   ra;

  fcmd_t fcmd;
  ucmd_t ucmd;
  logic  ftok_in;
  logic  utok_in;

  fent_t fe   [MAX_FREE_BLOCKS];
  logic  fpre [MAX_FREE_BLOCKS];
  logic  fbnd [MAX_FREE_BLOCKS];
  uent_t ue   [MAX_USED_BLOCKS];

  logic [MAX_FREE_BLOCKS-1:0] ftok_vec;
  logic [MAX_FREE_BLOCKS-1:0] fvalid_vec;
  logic [MAX_USED_BLOCKS-1:0] um_vec;

  fent_t head_ent;
  fent_t tail_ent;

  assign head_ent = '{valid: 1'b0, start: '0, len: '0, r: 1'b0, fit: 1'b0, tok: ftok_in};
  assign tail_ent = '{valid: 1'b0, start: '0, len: '0, r: 1'b1, fit: 1'b0, tok: 1'b0};

  for (genvar k = 0; k < MAX_FREE_BLOCKS; k++) begin : g_free
    fent_t prv;
    fent_t nxt;
    if (k == 0) begin : g_first
      assign prv = head_ent;
    end else begin : g_mid
      assign prv = fe[k-1];
    end
    if (k == MAX_FREE_BLOCKS - 1) begin : g_last
      assign nxt = tail_ent;
    end else begin : g_inner
      assign nxt = fe[k+1];
    end
    ffha_free_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .is_head (k == 0),
      .cmd     (fcmd),
      .prv     (prv),
      .nxt     (nxt),
      .ent     (fe[k]),
      .pre     (fpre[k]),
      .bnd     (fbnd[k])
    );
    assign ftok_vec[k]   = fe[k].tok;
    assign fvalid_vec[k] = fe[k].valid;
  end

  for (genvar k = 0; k < MAX_USED_BLOCKS; k++) begin : g_used
    logic prv_tok;
    if (k == 0) begin : g_first
      assign prv_tok = utok_in;
    end else begin : g_mid
      assign prv_tok = ue[k-1].tok;
    end
    ffha_used_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (ucmd),
      .prv_tok (prv_tok),
      .ent     (ue[k])
    );
    assign um_vec[k] = ue[k].m;
  end

  // read buses: one-hot selects OR'd together
  logic              fhit;
  logic [ADDR_W-1:0] fb_start;
  logic [ADDR_W-1:0] fb_len;
  logic              pb_valid;
  logic [ADDR_W-1:0] pb_start;
  logic [ADDR_W-1:0] pb_len;
  logic              nb_valid;
  logic [ADDR_W-1:0] nb_start;
  logic              uhit;
  logic              umatch;
  logic [ADDR_W-1:0] msize;

  always_comb begin
    fhit     = 1'b0;
    fb_start = '0;
    fb_len   = '0;
    pb_valid = 1'b0;
    pb_start = '0;
    pb_len   = '0;
    nb_valid = 1'b0;
    nb_start = '0;
    for (int k = 0; k < MAX_FREE_BLOCKS; k++) begin
      fhit     = fhit | (fe[k].tok & fe[k].fit);
      fb_start = fb_start | ({ADDR_W{fe[k].tok}} & fe[k].start);
      fb_len   = fb_len | ({ADDR_W{fe[k].tok}} & fe[k].len);
      pb_valid = pb_valid | (fpre[k] & fe[k].valid);
      pb_start = pb_start | ({ADDR_W{fpre[k]}} & fe[k].start);
      pb_len   = pb_len | ({ADDR_W{fpre[k]}} & fe[k].len);
      nb_valid = nb_valid | (fbnd[k] & fe[k].valid);
      nb_start = nb_start | ({ADDR_W{fbnd[k]}} & fe[k].start);
    end
  end

  always_comb begin
    uhit   = 1'b0;
    umatch = 1'b0;
    msize  = '0;
    for (int k = 0; k < MAX_USED_BLOCKS; k++) begin
      uhit   = uhit | (ue[k].tok & !ue[k].valid);
      umatch = umatch | ue[k].m;
      msize  = msize | ({ADDR_W{ue[k].m}} & ue[k].size);
    end
  end

  logic [ADDR_W-1:0] heap_sat;
  logic [TOT_W-1:0]  user;
  logic [ADDR_W-1:0] blk;
  logic              join_prev;
  logic              join_next;
  logic              in_fire;
  logic              scan_end;

  always_comb begin
    if (heap_bytes < ADDR_W'(MIN_HEAP_BYTES)) begin
      heap_sat = ADDR_W'(MIN_HEAP_BYTES);
    end else if (heap_bytes > ADDR_W'(MAX_HEAP_BYTES)) begin
      heap_sat = ADDR_W'(MAX_HEAP_BYTES);
    end else begin
      heap_sat = heap_bytes;
    end
  end

  assign user      = {1'b0, fs} + {1'b0, fl} - size;
  assign blk       = ua - ADDR_W'(HEADER_BYTES);
  assign join_prev = pv && (({1'b0, ps} + {1'b0, pl}) == {1'b0, blk});
  assign join_next = nv && ({1'b0, ns} == ({1'b0, blk} + tot));
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign scan_end  = (cnt == SCAN_W'(MAX_FREE_BLOCKS - 1));

  always_comb begin
    fcmd    = '{op: F_IDLE, key: '0, start: '0, total: tot,
                total16: {1'b0, tot} + (TOT_W+1)'(FREE_HEADER_BYTES)};
    ucmd    = '{op: U_IDLE, start: '0, size: '0};
    ftok_in = 1'b0;
    utok_in = 1'b0;
    case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          fcmd.op  = F_INIT;
          fcmd.key = heap_sat;
          ucmd.op  = U_INIT;
        end
      end
      S_AMARK: begin
        fcmd.op = F_MARK;
        ucmd.op = U_MARK;
      end
      S_AFSTART: begin
        fcmd.op = F_SCAN;
        ftok_in = 1'b1;
      end
      S_AFSCAN: begin
        if (!fhit && !scan_end) fcmd.op = F_SCAN;
      end
      S_AUSTART: begin
        ucmd.op = U_SCAN;
        utok_in = 1'b1;
      end
      S_AUSCAN: begin
        if (!uhit && cnt != SCAN_W'(MAX_USED_BLOCKS - 1)) ucmd.op = U_SCAN;
      end
      S_ACOMMIT: begin
        ucmd.op    = U_WRITE;
        ucmd.start = user[ADDR_W-1:0];
        ucmd.size  = size[ADDR_W-1:0];
        if ({1'b0, fl} == tot) begin
          fcmd.op  = F_MARK;
          fcmd.key = fs;
        end else begin
          fcmd.op = F_SUB_TOK;
        end
      end
      S_ADEL: begin
        fcmd.op = F_DELETE;
      end
      S_FMATCH: begin
        ucmd.op    = U_MARK;
        ucmd.start = ua;
      end
      S_FLOOK: begin
        if (umatch) begin
          fcmd.op  = F_MARK;
          fcmd.key = ua - ADDR_W'(HEADER_BYTES - 1);
        end
      end
      S_FJOIN: begin
        fcmd.start = blk;
        if (join_prev) begin
          fcmd.op = F_ADD_PRE;
        end else if (join_next) begin
          fcmd.op = F_SET_BND;
        end else if (fcount != FCNT_W'(MAX_FREE_BLOCKS)) begin
          fcmd.op = F_INSERT;
        end
      end
      S_FADDNX: begin
        fcmd.op = F_ADD_NEXT;
      end
      S_FDEL: begin
        fcmd.op = F_DELETE;
      end
      S_FCLR: begin
        ucmd.op = U_CLEAR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fcount    <= FCNT_W'(1);
      out_valid <= 1'b0;
      pass      <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            fcount <= FCNT_W'(1);
          end else if (in_fire) begin
            req <= request_bytes;
            ua  <= user_address;
            ra  <= '0;
            if (kind) begin
              state <= S_FMATCH;
            end else if (request_bytes == '0) begin
              st    <= ST_ZERO;
              state <= S_DONE;
            end else begin
              size  <= ({1'b0, request_bytes} + TOT_W'(FREE_HEADER_BYTES - 1)) & RND_MASK;
              tot   <= (({1'b0, request_bytes} + TOT_W'(FREE_HEADER_BYTES - 1)) & RND_MASK)
                       + TOT_W'(HEADER_BYTES);
              pass  <= 1'b0;
              state <= S_AMARK;
            end
          end
        end
        S_AMARK: state <= S_AFSTART;
        S_AFSTART: begin
          cnt   <= '0;
          state <= S_AFSCAN;
        end
        S_AFSCAN: begin
          if (fhit) begin
            fs    <= fb_start;
            fl    <= fb_len;
            state <= S_AUSTART;
          end else if (scan_end) begin
            if (!pass) begin
              pass  <= 1'b1;
              size  <= {1'b0, req};
              tot   <= {1'b0, req} + TOT_W'(HEADER_BYTES);
              state <= S_AMARK;
            end else begin
              st    <= ST_NO_FIT;
              state <= S_DONE;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_AUSTART: begin
          cnt   <= '0;
          state <= S_AUSCAN;
        end
        S_AUSCAN: begin
          if (uhit) begin
            state <= S_ACOMMIT;
          end else if (cnt == SCAN_W'(MAX_USED_BLOCKS - 1)) begin
            st    <= ST_FULL;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ACOMMIT: begin
          st <= ST_OK;
          ra <= user[ADDR_W-1:0];
          if ({1'b0, fl} == tot) begin
            state <= S_ADEL;
          end else begin
            state <= S_DONE;
          end
        end
        S_ADEL: begin
          fcount <= fcount - 1'b1;
          state  <= S_DONE;
        end
        S_FMATCH: state <= S_FLOOK;
        S_FLOOK: begin
          if (umatch) begin
            tot   <= {1'b0, msize} + TOT_W'(HEADER_BYTES);
            state <= S_FNB;
          end else begin
            st    <= ST_BAD_FREE;
            state <= S_DONE;
          end
        end
        S_FNB: begin
          pv    <= pb_valid;
          ps    <= pb_start;
          pl    <= pb_len;
          nv    <= nb_valid;
          ns    <= nb_start;
          state <= S_FJOIN;
        end
        S_FJOIN: begin
          if (join_prev && join_next) begin
            state <= S_FADDNX;
          end else if (join_prev || join_next) begin
            state <= S_FCLR;
          end else if (fcount != FCNT_W'(MAX_FREE_BLOCKS)) begin
            fcount <= fcount + 1'b1;
            state  <= S_FCLR;
          end else begin
            st    <= ST_FULL;
            state <= S_DONE;
          end
        end
        S_FADDNX: state <= S_FDEL;
        S_FDEL: begin
          fcount <= fcount - 1'b1;
          state  <= S_FCLR;
        end
        S_FCLR: begin
          st    <= ST_OK;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            status         <= st;
            result_address <= ra;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ftok_single: assert property (@(posedge clk) disable iff (rst) $onehot0(ftok_vec))
    else $error("more than one free list token");
  a_umatch_single: assert property (@(posedge clk) disable iff (rst) $onehot0(um_vec))
    else $error("address matches several live allocations");
  a_fcount: assert property (@(posedge clk) disable iff (rst)
    $countones(fvalid_vec) == int'(fcount))
    else $error("free count disagrees with valid free entries");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("second transaction taken while one is in progress");
`endif

endmodule
`default_nettype wire
